// ===== design/sparse_logical_and_or_merge_macros.svh =====
`ifndef SPARSE_LOGICAL_AND_OR_MERGE_MACROS_SVH
`define SPARSE_LOGICAL_AND_OR_MERGE_MACROS_SVH

// Checks sampled on the rising clock edge, off while reset is asserted.
`define SLAOM_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("%m: check failed");

`define SLAOM_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("%m: check failed");

`endif

// ===== design/slaom_pkg.sv =====
package slaom_pkg;

	localparam int unsigned LIST_DEPTH = 32;
	localparam int unsigned POS_BITS = 16;
	localparam int unsigned CMD_QUEUE_DEPTH = 4;
	localparam int unsigned RESULT_QUEUE_DEPTH = 2;

	localparam logic [1:0] CMD_PUSH_A = 2'd0;
	localparam logic [1:0] CMD_PUSH_B = 2'd1;
	localparam logic [1:0] CMD_RUN = 2'd2;

	localparam logic OP_AND = 1'b0;
	localparam logic OP_OR = 1'b1;

	typedef struct packed {
		logic [1:0] command;
		logic [POS_BITS-1:0] position;
		logic is_na;
	} item_t;

	typedef struct packed {
		logic [POS_BITS-1:0] out_position;
		logic out_is_na;
		logic last_entry;
		logic empty_result;
		logic overflowed;
	} result_t;

	typedef struct packed {
		logic [1:0] op;
		logic [POS_BITS-1:0] position;
		logic is_na;
	} cmd_t;

	typedef struct packed {
		logic is_na;
		logic [POS_BITS-1:0] position;
	} entry_t;

endpackage

// ===== design/slaom_ram.sv =====
module slaom_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/slaom_fifo.sv =====
module slaom_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [WIDTH-1:0] wdata,
	output logic full,
	input logic rd_en,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/slaom_front.sv =====
module slaom_front (
	input logic push,
	input slaom_pkg::item_t item,
	output logic full,
	input logic q_full,
	output logic enq,
	output slaom_pkg::cmd_t enq_word
);

	logic accept;
	logic known_cmd;

	assign full = q_full;
	assign accept = push && !q_full;

	// The unused command code is accepted and dropped here.
	assign known_cmd = (item.command == slaom_pkg::CMD_PUSH_A) ||
		(item.command == slaom_pkg::CMD_PUSH_B) ||
		(item.command == slaom_pkg::CMD_RUN);

	assign enq = accept && known_cmd;

	always_comb begin
		enq_word.op = item.command;
		enq_word.position = item.position;
		enq_word.is_na = item.is_na;
	end

endmodule

// ===== design/slaom_back.sv =====
module slaom_back #(
	parameter int unsigned LIST_DEPTH = slaom_pkg::LIST_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic logic_op,
	input logic cmd_empty,
	input slaom_pkg::cmd_t cmd_word,
	output logic cmd_pop,
	input logic res_full,
	output logic res_push,
	output slaom_pkg::result_t res_word
);

	localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned EW = $bits(slaom_pkg::entry_t);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MERGE = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_a_q, cnt_a_d;
	logic [CW-1:0] cnt_b_q, cnt_b_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;
	logic ovf_q, ovf_d;
	logic pend_valid_q, pend_valid_d;
	slaom_pkg::entry_t pend_q, pend_d;

	logic wr_a;
	logic wr_b;
	slaom_pkg::entry_t wr_entry;
	logic [EW-1:0] a_rdata;
	logic [EW-1:0] b_rdata;
	slaom_pkg::entry_t a_head;
	slaom_pkg::entry_t b_head;

	logic has_a;
	logic has_b;
	logic take_a;
	logic take_b;
	logic hit;
	logic hit_na;
	logic any_true;

	assign wr_entry.is_na = cmd_word.is_na;
	assign wr_entry.position = cmd_word.position;
	assign a_head = slaom_pkg::entry_t'(a_rdata);
	assign b_head = slaom_pkg::entry_t'(b_rdata);

	// The read address follows the next index, so the heads are current each cycle.
	slaom_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_ram_a (
		.clk(clk),
		.we(wr_a),
		.waddr(cnt_a_q[AW-1:0]),
		.wdata(wr_entry),
		.raddr(i_d[AW-1:0]),
		.rdata(a_rdata)
	);

	slaom_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_ram_b (
		.clk(clk),
		.we(wr_b),
		.waddr(cnt_b_q[AW-1:0]),
		.wdata(wr_entry),
		.raddr(j_d[AW-1:0]),
		.rdata(b_rdata)
	);

	always_comb begin
		has_a = (i_q < cnt_a_q);
		has_b = (j_q < cnt_b_q);
		if (has_a && has_b) begin
			take_a = (a_head.position <= b_head.position);
			take_b = (b_head.position <= a_head.position);
		end else begin
			take_a = has_a;
			take_b = !has_a;
		end
		any_true = (take_a && !a_head.is_na) || (take_b && !b_head.is_na);
		if (logic_op == slaom_pkg::OP_AND) begin
			hit = take_a && take_b;
			hit_na = a_head.is_na || b_head.is_na;
		end else begin
			hit = take_a || take_b;
			hit_na = !any_true;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_a_d = cnt_a_q;
		cnt_b_d = cnt_b_q;
		i_d = i_q;
		j_d = j_q;
		ovf_d = ovf_q;
		pend_valid_d = pend_valid_q;
		pend_d = pend_q;
		cmd_pop = 1'b0;
		wr_a = 1'b0;
		wr_b = 1'b0;
		res_push = 1'b0;
		res_word = '0;
		res_word.overflowed = ovf_q;
		case (state_q)
			ST_IDLE: begin
				i_d = '0;
				j_d = '0;
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					case (cmd_word.op)
						slaom_pkg::CMD_PUSH_A: begin
							if (cnt_a_q == CW'(LIST_DEPTH)) begin
								ovf_d = 1'b1;
							end else begin
								wr_a = 1'b1;
								cnt_a_d = cnt_a_q + 1'b1;
							end
						end
						slaom_pkg::CMD_PUSH_B: begin
							if (cnt_b_q == CW'(LIST_DEPTH)) begin
								ovf_d = 1'b1;
							end else begin
								wr_b = 1'b1;
								cnt_b_d = cnt_b_q + 1'b1;
							end
						end
						slaom_pkg::CMD_RUN: begin
							pend_valid_d = 1'b0;
							state_d = ST_MERGE;
						end
						default: begin
						end
					endcase
				end
			end
			ST_MERGE: begin
				if (!has_a && !has_b) begin
					state_d = ST_FLUSH;
				end else if (!res_full) begin
					if (take_a) begin
						i_d = i_q + 1'b1;
					end
					if (take_b) begin
						j_d = j_q + 1'b1;
					end
					// One result is held back so that the final one can be marked.
					if (hit) begin
						pend_d.position = take_a ? a_head.position : b_head.position;
						pend_d.is_na = hit_na;
						pend_valid_d = 1'b1;
						if (pend_valid_q) begin
							res_push = 1'b1;
							res_word.out_position = pend_q.position;
							res_word.out_is_na = pend_q.is_na;
						end
					end
				end
			end
			ST_FLUSH: begin
				if (!res_full) begin
					res_push = 1'b1;
					res_word.last_entry = 1'b1;
					if (pend_valid_q) begin
						res_word.out_position = pend_q.position;
						res_word.out_is_na = pend_q.is_na;
					end else begin
						res_word.empty_result = 1'b1;
					end
					cnt_a_d = '0;
					cnt_b_d = '0;
					ovf_d = 1'b0;
					pend_valid_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q <= '0;
			j_q <= '0;
			ovf_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_a_q <= cnt_a_d;
			cnt_b_q <= cnt_b_d;
			i_q <= i_d;
			j_q <= j_d;
			ovf_q <= ovf_d;
			pend_valid_q <= pend_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
	end

endmodule

// ===== design/sparse_logical_and_or_merge.sv =====
// A push word is accepted into the command queue and is written to its list when the
// idle back end pops it. A run word leaves the queue while the back end is idle, and
// the merge walker then takes one list step per cycle while the result queue is not full.
// A flush step then writes the closing word. Pushes sustain one word per cycle while
// the command queue is not full; the merge walk sets the rate of a run.
// Reset clears both lists, the overflow flag, both queues and the operator register (AND).
module sparse_logical_and_or_merge #(
	parameter int unsigned LIST_DEPTH = slaom_pkg::LIST_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input slaom_pkg::item_t item,
	output logic empty,
	input logic pop,
	output slaom_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);

	localparam int unsigned CMD_W = $bits(slaom_pkg::cmd_t);
	localparam int unsigned RES_W = $bits(slaom_pkg::result_t);

	logic logic_op_q;
	logic q_full;
	logic enq;
	slaom_pkg::cmd_t enq_word;
	logic cmd_empty;
	logic cmd_pop;
	logic [CMD_W-1:0] cmd_rdata;
	logic res_full;
	logic res_push;
	slaom_pkg::result_t res_word;
	logic [RES_W-1:0] res_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logic_op_q <= slaom_pkg::OP_AND;
		end else if (cfg_valid && cfg_ready) begin
			logic_op_q <= cfg_data;
		end
	end

	slaom_front u_front (
		.push(push),
		.item(item),
		.full(full),
		.q_full(q_full),
		.enq(enq),
		.enq_word(enq_word)
	);

	slaom_fifo #(.WIDTH(CMD_W), .DEPTH(slaom_pkg::CMD_QUEUE_DEPTH)) u_cmd_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(enq),
		.wdata(enq_word),
		.full(q_full),
		.rd_en(cmd_pop),
		.rdata(cmd_rdata),
		.empty(cmd_empty)
	);

	slaom_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.logic_op(logic_op_q),
		.cmd_empty(cmd_empty),
		.cmd_word(slaom_pkg::cmd_t'(cmd_rdata)),
		.cmd_pop(cmd_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res_word(res_word)
	);

	slaom_fifo #(.WIDTH(RES_W), .DEPTH(slaom_pkg::RESULT_QUEUE_DEPTH)) u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_push),
		.wdata(res_word),
		.full(res_full),
		.rd_en(pop),
		.rdata(res_rdata),
		.empty(empty)
	);

	assign result = slaom_pkg::result_t'(res_rdata);

endmodule

// ===== design/slaom_checker.sv =====
`include "sparse_logical_and_or_merge_macros.svh"

module slaom_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input slaom_pkg::result_t result,
	input logic cfg_ready
);

	// A waiting word that is not taken stays on the ports unchanged.
	`SLAOM_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result))

	// The word for an empty merge closes its run and carries no entry.
	`SLAOM_ASSERT(a_empty_word,
		!(!empty && result.empty_result) ||
		(result.last_entry && result.out_position == '0 && !result.out_is_na))

	// The configuration port never pushes back.
	`SLAOM_ASSERT(a_cfg_ready, cfg_ready)

endmodule

bind sparse_logical_and_or_merge slaom_checker u_checker (.*);
